@@ design/fpfa_pkg.sv @@
// fpfa_pkg: shared types and codes of the fixed-partition fit allocator
// used by the interfaces, the cells, the register block and the top level
// no dependencies
package fpfa_pkg;

    // field widths of the request and result channels
    localparam int OP_W     = 1;
    localparam int SLOT_W   = 4;
    localparam int AMOUNT_W = 16;
    localparam int CHOSEN_W = 4;
    localparam int LEFT_W   = 16;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int POLICY_W   = 2;
    localparam int COUNT_W    = 5;

    // register word index (byte address bit 2)
    localparam logic REG_FIT_POLICY = 1'b0;
    localparam logic REG_PART_COUNT = 1'b1;

    // reset values of the registers
    localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 5'd16;

    // fit policies; the unused code behaves as first fit
    localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

    // request opcodes
    localparam logic [OP_W-1:0] OP_LOAD    = 1'b0;
    localparam logic [OP_W-1:0] OP_REQUEST = 1'b1;

    // configuration as seen by the datapath
    typedef struct packed {
        logic [POLICY_W-1:0] policy;
        logic [COUNT_W-1:0]  count;
    } t_cfg;

    // flags that travel with the search record along the cell chain
    typedef struct packed {
        logic valid;
        logic found;
    } t_scan_ctl;

endpackage

@@ design/fpfa_if.sv @@
// fpfa_if: valid/ready channels of the fit allocator
// fpfa_item_if carries incoming requests, fpfa_res_if carries results
// depends on fpfa_pkg
interface fpfa_item_if;
    logic                          valid;
    logic                          ready;
    logic [fpfa_pkg::OP_W-1:0]     op;
    logic [fpfa_pkg::SLOT_W-1:0]   slot;
    logic [fpfa_pkg::AMOUNT_W-1:0] amount;

    modport source (output valid, op, slot, amount, input ready);
    modport sink   (input valid, op, slot, amount, output ready);
endinterface

interface fpfa_res_if;
    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [fpfa_pkg::CHOSEN_W-1:0] chosen;
    logic [fpfa_pkg::LEFT_W-1:0]   leftover;

    modport source (output valid, granted, chosen, leftover, input ready);
    modport sink   (input valid, granted, chosen, leftover, output ready);
endinterface

@@ design/fixed_partition_fit_allocator.sv @@
// fixed_partition_fit_allocator: top level of the fixed-partition fit allocator
// chain of fpfa_cell partitions, fpfa_cfg_regs, channels from fpfa_if
// depends on fpfa_pkg
//
//  channel   | dir | handshake             | payload
//  ----------+-----+-----------------------+--------------------------------
//  i_item    | in  | valid / ready         | op, slot, amount
//  o_res     | out | valid / ready         | granted, chosen, leftover
//  apb       | in  | psel, penable, pready | paddr, pwdata, prdata
//
// a request walks the partition chain one cell per cycle; at the chain end
// its result is held in the pending result register and then moves to the
// output register; a load writes the pending result register when it is
// accepted and does not enter the chain
// one item is in work at a time; the next is taken once the result sits in
// the output register, which holds it while o_res.ready is low
// reset is synchronous, active low; it frees all partitions, sizes stay unknown
module fixed_partition_fit_allocator #(
    parameter int PARTITIONS = 16,
    parameter int SIZE_BITS  = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fpfa_item_if.sink                       i_item,
    fpfa_res_if.source                      o_res,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fpfa_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fpfa_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fpfa_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fpfa_pkg::*;

    localparam int PIDX_W = (PARTITIONS > 1) ? $clog2(PARTITIONS) : 1;
    localparam int IDX_W  = (PIDX_W > CHOSEN_W) ? PIDX_W : CHOSEN_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    t_cfg cfg;

    fpfa_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic                accept;
    logic                out_free;
    logic                scan_end;
    logic                slot_ok;
    logic [SIZE_BITS-1:0] item_amount;

    // pending result, waiting for the output register
    logic                r_res_granted;
    logic [CHOSEN_W-1:0] r_res_chosen;
    logic [LEFT_W-1:0]   r_res_left;

    // output register
    logic                r_out_valid;
    logic                r_out_granted;
    logic [CHOSEN_W-1:0] r_out_chosen;
    logic [LEFT_W-1:0]   r_out_left;

    // search record along the chain
    t_scan_ctl            chain_ctl    [PARTITIONS+1];
    logic [SIZE_BITS-1:0] chain_amount [PARTITIONS+1];
    logic [IDX_W-1:0]     chain_idx    [PARTITIONS+1];
    logic [SIZE_BITS-1:0] chain_left   [PARTITIONS+1];

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign out_free     = !r_out_valid || o_res.ready;
    assign scan_end     = chain_ctl[PARTITIONS].valid;
    assign slot_ok      = 32'(i_item.slot) < 32'(PARTITIONS);
    assign item_amount  = SIZE_BITS'(i_item.amount);

    // record entering the first cell
    always_comb begin
        chain_ctl[0].valid = accept && (i_item.op == OP_REQUEST);
        chain_ctl[0].found = 1'b0;
        chain_amount[0]    = item_amount;
        chain_idx[0]       = '0;
        chain_left[0]      = '0;
    end

    // partition cells
    for (genvar j = 0; j < PARTITIONS; j++) begin : g_cell
        logic load_en;
        logic mark_en;

        assign load_en = accept && (i_item.op == OP_LOAD)
                         && (32'(i_item.slot) == 32'(j));
        assign mark_en = scan_end && chain_ctl[PARTITIONS].found
                         && (chain_idx[PARTITIONS] == IDX_W'(j));

        fpfa_cell #(
            .CELL_IDX  (j),
            .SIZE_BITS (SIZE_BITS),
            .IDX_W     (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_cfg       (cfg),
            .i_load_en   (load_en),
            .i_load_size (item_amount),
            .i_mark_en   (mark_en),
            .i_ctl       (chain_ctl[j]),
            .i_amount    (chain_amount[j]),
            .i_idx       (chain_idx[j]),
            .i_left      (chain_left[j]),
            .o_ctl       (chain_ctl[j+1]),
            .o_amount    (chain_amount[j+1]),
            .o_idx       (chain_idx[j+1]),
            .o_left      (chain_left[j+1])
        );
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_item.op == OP_LOAD) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // capture the result of a load or of the finished scan
    always_ff @(posedge i_clk) begin
        if (accept && (i_item.op == OP_LOAD)) begin
            r_res_granted <= slot_ok;
            r_res_chosen  <= i_item.slot;
            r_res_left    <= '0;
        end else if ((r_state == ST_SCAN) && scan_end) begin
            r_res_granted <= chain_ctl[PARTITIONS].found;
            r_res_chosen  <= chain_ctl[PARTITIONS].found
                             ? chain_idx[PARTITIONS][CHOSEN_W-1:0] : '0;
            r_res_left    <= chain_ctl[PARTITIONS].found
                             ? LEFT_W'(chain_left[PARTITIONS]) : '0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_out_granted <= r_res_granted;
            r_out_chosen  <= r_res_chosen;
            r_out_left    <= r_res_left;
        end
    end

    assign o_res.valid    = r_out_valid;
    assign o_res.granted  = r_out_granted;
    assign o_res.chosen   = r_out_chosen;
    assign o_res.leftover = r_out_left;

endmodule

@@ design/fpfa_cfg_regs.sv @@
// fpfa_cfg_regs: apb register block holding fit policy and partition count
// depends on fpfa_pkg
module fpfa_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [fpfa_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [fpfa_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [fpfa_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    output fpfa_pkg::t_cfg                    o_cfg
);
    import fpfa_pkg::*;

    logic [POLICY_W-1:0] r_policy;
    logic [COUNT_W-1:0]  r_count;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, decoded on the word index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= POLICY_RESET;
            r_count  <= COUNT_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_FIT_POLICY: r_policy <= pwdata[POLICY_W-1:0];
                REG_PART_COUNT: r_count  <= pwdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // read back
    always_comb begin
        unique case (paddr[2])
            REG_FIT_POLICY: prdata = APB_DATA_W'(r_policy);
            REG_PART_COUNT: prdata = APB_DATA_W'(r_count);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg.policy = r_policy;
    assign o_cfg.count  = r_count;

endmodule

@@ design/fpfa_cell.sv @@
// fpfa_cell: one partition of the allocator chain
// holds the partition size and in-use mark, updates the passing search record
// depends on fpfa_pkg
module fpfa_cell #(
    parameter int CELL_IDX  = 0,
    parameter int SIZE_BITS = 16,
    parameter int IDX_W     = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpfa_pkg::t_cfg       i_cfg,
    input  logic                 i_load_en,
    input  logic [SIZE_BITS-1:0] i_load_size,
    input  logic                 i_mark_en,
    input  fpfa_pkg::t_scan_ctl  i_ctl,
    input  logic [SIZE_BITS-1:0] i_amount,
    input  logic [IDX_W-1:0]     i_idx,
    input  logic [SIZE_BITS-1:0] i_left,
    output fpfa_pkg::t_scan_ctl  o_ctl,
    output logic [SIZE_BITS-1:0] o_amount,
    output logic [IDX_W-1:0]     o_idx,
    output logic [SIZE_BITS-1:0] o_left
);
    import fpfa_pkg::*;

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_used;
    t_scan_ctl            r_ctl;
    logic [SIZE_BITS-1:0] r_amount;
    logic [IDX_W-1:0]     r_idx;
    logic [SIZE_BITS-1:0] r_left;

    t_scan_ctl            n_ctl;
    logic [SIZE_BITS-1:0] n_left;
    logic [IDX_W-1:0]     n_idx;
    logic                 active;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic [SIZE_BITS-1:0] my_left;

    // partition size, no reset
    always_ff @(posedge i_clk) begin
        if (i_load_en) begin
            r_size <= i_load_size;
        end
    end

    // in-use mark: a load frees, a grant takes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_load_en) begin
            r_used <= 1'b0;
        end else if (i_mark_en) begin
            r_used <= 1'b1;
        end
    end

    // candidate test against the record coming from the left neighbor
    assign active  = 32'(CELL_IDX) < 32'(i_cfg.count);
    assign fits    = active && !r_used && (r_size >= i_amount);
    assign my_left = r_size - i_amount;

    always_comb begin
        case (i_cfg.policy)
            FIT_BEST:  better = my_left < i_left;
            FIT_WORST: better = my_left > i_left;
            default:   better = 1'b0;
        endcase
    end

    assign take = i_ctl.valid && fits && (!i_ctl.found || better);

    always_comb begin
        n_ctl.valid = i_ctl.valid;
        n_ctl.found = i_ctl.found || take;
        n_idx       = take ? IDX_W'(CELL_IDX) : i_idx;
        n_left      = take ? my_left : i_left;
    end

    // hand the record to the right neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_amount <= i_amount;
        r_idx    <= n_idx;
        r_left   <= n_left;
    end

    assign o_ctl    = r_ctl;
    assign o_amount = r_amount;
    assign o_idx    = r_idx;
    assign o_left   = r_left;

endmodule

@@ design/fpfa_checker.sv @@
// fpfa_checker: port-level checks of the fit allocator and its bind
// depends on fpfa_pkg and fixed_partition_fit_allocator
module fpfa_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic                            i_out_granted,
    input logic [fpfa_pkg::CHOSEN_W-1:0]   i_out_chosen,
    input logic [fpfa_pkg::LEFT_W-1:0]     i_out_leftover
);
    import fpfa_pkg::*;

    logic in_acc;

    assign in_acc = i_in_valid && i_in_ready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
            && $stable({i_out_granted, i_out_chosen, i_out_leftover}))
        else $error("result changed while stalled");

    // a refused request or load reports no leftover
    a_refuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_granted |-> i_out_leftover == '0)
        else $error("refusal with nonzero leftover");

    // one request in work at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !i_in_ready)
        else $error("ready held high after accept");

    // a new result never shows right after an accept
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(in_acc))
        else $error("result appeared one cycle after accept");

endmodule

bind fixed_partition_fit_allocator fpfa_checker u_fpfa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_item.valid),
    .i_in_ready     (i_item.ready),
    .i_out_valid    (o_res.valid),
    .i_out_ready    (o_res.ready),
    .i_out_granted  (o_res.granted),
    .i_out_chosen   (o_res.chosen),
    .i_out_leftover (o_res.leftover)
);
